/* rtl/core/tils_pkg.sv */
`default_nettype none

package tils_pkg;

  localparam int NUM_BANDS = 16;
  localparam int BAND_AW   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int NUM_SLOTS = 4;
  localparam int DIV_STEPS = 17;

  localparam logic [1:0] REQ_POS    = 2'd0;
  localparam logic [1:0] REQ_ENERGY = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] CUT_LO  = 2'd0;
  localparam logic [1:0] CUT_MID = 2'd1;
  localparam logic [1:0] CUT_HI  = 2'd2;

  localparam logic [1:0] SLOT_START [NUM_SLOTS] = '{2'd0, 2'd1, 2'd2, 2'd3};

  typedef struct packed {
    logic       wr_pos;
    logic       wr_energy;
    logic       query_ld;
    logic       sort_ld;
    logic       sort1;
    logic       sort2;
    logic       sort3;
    logic       classify;
    logic       div_init;
    logic       div_step;
    logic       rd_base;
    logic       rd_other;
    logic       mul;
    logic       add;
    logic [1:0] axis;
    logic [1:0] pt;
    logic       out_pt;
    logic       out_ns;
  } tils_cmd_t;

  typedef struct packed {
    logic nosurf;
    logic last;
  } tils_sts_t;

endpackage

`default_nettype wire

/* rtl/core/tils_dpath.sv */
`default_nettype none

module tils_dpath (
  input  logic                clk_i,
  input  tils_pkg::tils_cmd_t cmd_i,
  output tils_pkg::tils_sts_t sts_o,
  input  logic [1:0]          vertex_slot_i,
  input  logic [3:0]          band_i,
  input  logic [31:0]         coord_x_i,
  input  logic [31:0]         coord_y_i,
  input  logic [31:0]         coord_z_i,
  input  logic [31:0]         energy_i,
  input  logic [31:0]         iso_level_i,
  output logic [31:0]         point_x_o,
  output logic [31:0]         point_y_o,
  output logic [31:0]         point_z_o,
  output logic [2:0]          corner_count_o,
  output logic                status_o,
  output logic                last_point_o
);

  logic [95:0] pos_mem [tils_pkg::NUM_SLOTS];
  logic [31:0] e_mem [tils_pkg::NUM_SLOTS][tils_pkg::NUM_BANDS];
  logic [31:0] e_rd_q [tils_pkg::NUM_SLOTS];
  logic [95:0] pos_rd_q, base_q;

  logic signed [31:0] e_q [tils_pkg::NUM_SLOTS];
  logic [1:0]  s_q [tils_pkg::NUM_SLOTS];
  logic signed [31:0] lvl_q;
  logic [3:0]  band_q;
  logic [1:0]  case_q;

  logic [1:0]  sb_q, so_q;
  logic [33:0] rem_q;
  logic [32:0] den_q;
  logic [16:0] q_q;
  logic        zero_q;
  logic signed [49:0] prod_q;

  logic [31:0] px_q, py_q, pz_q;
  logic [2:0]  cnt_q;
  logic        status_q, last_q;

  logic        band_ok_in, band_ok_q, nosurf;
  logic [tils_pkg::BAND_AW-1:0] addr_in;
  logic signed [32:0] le0, le1, le2, le3, lv, num, den;
  logic [1:0]  bi_s, oi_s;
  logic        ge;
  logic [33:0] rtmp;
  logic [15:0] t;
  logic [31:0] b_ax, o_ax;
  logic signed [32:0] d_s;
  logic signed [16:0] t_s;
  logic signed [49:0] prod_d;
  logic [1:0]  last_pt;

  assign band_ok_in = 32'(band_i) < tils_pkg::NUM_BANDS;
  assign band_ok_q  = 32'(band_q) < tils_pkg::NUM_BANDS;
  assign addr_in    = tils_pkg::BAND_AW'(band_i);

  // storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_pos) begin
      pos_mem[vertex_slot_i] <= {coord_z_i, coord_y_i, coord_x_i};
    end
    if (cmd_i.rd_base || cmd_i.rd_other) begin
      pos_rd_q <= pos_mem[cmd_i.rd_base ? sb_q : so_q];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < tils_pkg::NUM_SLOTS; g++) begin
      if (cmd_i.wr_energy && band_ok_in && (32'(vertex_slot_i) == g)) begin
        e_mem[g][addr_in] <= energy_i;
      end
      if (cmd_i.query_ld) begin
        e_rd_q[g] <= e_mem[g][addr_in];
      end
    end
  end

  // sorting network and classification
  assign le0 = 33'(e_q[0]);
  assign le1 = 33'(e_q[1]);
  assign le2 = 33'(e_q[2]);
  assign le3 = 33'(e_q[3]);
  assign lv  = 33'(lvl_q);
  assign nosurf = !band_ok_q || (lvl_q < e_q[0]) || (lvl_q > e_q[3]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_ld) begin
      lvl_q  <= iso_level_i;
      band_q <= band_i;
    end
    if (cmd_i.sort_ld) begin
      for (int g = 0; g < tils_pkg::NUM_SLOTS; g++) begin
        e_q[g] <= e_rd_q[g];
        s_q[g] <= tils_pkg::SLOT_START[g];
      end
    end
    if (cmd_i.sort1) begin
      if (e_q[0] > e_q[1]) begin
        e_q[0] <= e_q[1]; e_q[1] <= e_q[0];
        s_q[0] <= s_q[1]; s_q[1] <= s_q[0];
      end
      if (e_q[2] > e_q[3]) begin
        e_q[2] <= e_q[3]; e_q[3] <= e_q[2];
        s_q[2] <= s_q[3]; s_q[3] <= s_q[2];
      end
    end
    if (cmd_i.sort2) begin
      if (e_q[0] > e_q[2]) begin
        e_q[0] <= e_q[2]; e_q[2] <= e_q[0];
        s_q[0] <= s_q[2]; s_q[2] <= s_q[0];
      end
      if (e_q[1] > e_q[3]) begin
        e_q[1] <= e_q[3]; e_q[3] <= e_q[1];
        s_q[1] <= s_q[3]; s_q[3] <= s_q[1];
      end
    end
    if (cmd_i.sort3) begin
      if (e_q[1] > e_q[2]) begin
        e_q[1] <= e_q[2]; e_q[2] <= e_q[1];
        s_q[1] <= s_q[2]; s_q[2] <= s_q[1];
      end
    end
    if (cmd_i.classify) begin
      if (lvl_q < e_q[1]) begin
        case_q <= tils_pkg::CUT_LO;
      end else if (lvl_q < e_q[2]) begin
        case_q <= tils_pkg::CUT_MID;
      end else begin
        case_q <= tils_pkg::CUT_HI;
      end
    end
  end

  // edge of the current point
  always_comb begin
    num  = '0;
    den  = '0;
    bi_s = 2'd0;
    oi_s = 2'd0;
    case (case_q)
      tils_pkg::CUT_LO: begin
        num  = lv - le0;
        bi_s = 2'd0;
        case (cmd_i.pt)
          2'd0: begin den = le1 - le0; oi_s = 2'd1; end
          2'd1: begin den = le2 - le0; oi_s = 2'd2; end
          default: begin den = le3 - le0; oi_s = 2'd3; end
        endcase
      end
      tils_pkg::CUT_MID: begin
        case (cmd_i.pt)
          2'd0: begin num = lv - le0; den = le2 - le0; bi_s = 2'd0; oi_s = 2'd2; end
          2'd1: begin num = lv - le0; den = le3 - le0; bi_s = 2'd0; oi_s = 2'd3; end
          2'd2: begin num = le2 - lv; den = le2 - le1; bi_s = 2'd2; oi_s = 2'd1; end
          default: begin num = lv - le1; den = le3 - le1; bi_s = 2'd1; oi_s = 2'd3; end
        endcase
      end
      default: begin
        num  = le3 - lv;
        bi_s = 2'd3;
        case (cmd_i.pt)
          2'd0: begin den = le3 - le2; oi_s = 2'd2; end
          2'd1: begin den = le3 - le1; oi_s = 2'd1; end
          default: begin den = le3 - le0; oi_s = 2'd0; end
        endcase
      end
    endcase
  end

  // restoring divider, one quotient bit a cycle
  assign ge   = rem_q >= {1'b0, den_q};
  assign rtmp = ge ? rem_q - {1'b0, den_q} : rem_q;
  assign t    = zero_q ? 16'd0 : (q_q[16] ? 16'hFFFF : q_q[15:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q  <= {1'b0, num};
      den_q  <= den;
      q_q    <= '0;
      zero_q <= (num <= 0) || (den <= 0);
      case (bi_s)
        2'd0: sb_q <= s_q[0];
        2'd1: sb_q <= s_q[1];
        2'd2: sb_q <= s_q[2];
        default: sb_q <= s_q[3];
      endcase
      case (oi_s)
        2'd0: so_q <= s_q[0];
        2'd1: so_q <= s_q[1];
        2'd2: so_q <= s_q[2];
        default: so_q <= s_q[3];
      endcase
    end
    if (cmd_i.div_step) begin
      rem_q <= {rtmp[32:0], 1'b0};
      q_q   <= {q_q[15:0], ge};
    end
  end

  // interpolation, one axis at a time
  always_comb begin
    case (cmd_i.axis)
      2'd0: begin b_ax = base_q[31:0];  o_ax = pos_rd_q[31:0];  end
      2'd1: begin b_ax = base_q[63:32]; o_ax = pos_rd_q[63:32]; end
      default: begin b_ax = base_q[95:64]; o_ax = pos_rd_q[95:64]; end
    endcase
  end

  assign d_s    = 33'(signed'(o_ax)) - 33'(signed'(b_ax));
  assign t_s    = signed'({1'b0, t});
  assign prod_d = d_s * t_s;
  assign last_pt = (case_q == tils_pkg::CUT_MID) ? 2'd3 : 2'd2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_other) begin
      base_q <= pos_rd_q;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.add) begin
      case (cmd_i.axis)
        2'd0: px_q <= b_ax + prod_q[47:16];
        2'd1: py_q <= b_ax + prod_q[47:16];
        default: pz_q <= b_ax + prod_q[47:16];
      endcase
    end
    if (cmd_i.out_pt) begin
      cnt_q    <= (case_q == tils_pkg::CUT_MID) ? 3'd4 : 3'd3;
      status_q <= 1'b0;
      last_q   <= cmd_i.pt == last_pt;
    end
    if (cmd_i.out_ns) begin
      px_q     <= '0;
      py_q     <= '0;
      pz_q     <= '0;
      cnt_q    <= '0;
      status_q <= 1'b1;
      last_q   <= 1'b1;
    end
  end

  assign sts_o.nosurf   = nosurf;
  assign sts_o.last     = last_q;
  assign point_x_o      = px_q;
  assign point_y_o      = py_q;
  assign point_z_o      = pz_q;
  assign corner_count_o = cnt_q;
  assign status_o       = status_q;
  assign last_point_o   = last_q;

endmodule

`default_nettype wire

/* rtl/core/tils_ctrl.sv */
`default_nettype none

module tils_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          req_type_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tils_pkg::tils_cmd_t cmd_o,
  input  tils_pkg::tils_sts_t sts_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_S1   = 4'd2;
  localparam logic [3:0] ST_S2   = 4'd3;
  localparam logic [3:0] ST_S3   = 4'd4;
  localparam logic [3:0] ST_CLS  = 4'd5;
  localparam logic [3:0] ST_DINI = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_RDB  = 4'd8;
  localparam logic [3:0] ST_RDO  = 4'd9;
  localparam logic [3:0] ST_MUL  = 4'd10;
  localparam logic [3:0] ST_ADD  = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] axis_q, axis_d;
  logic [1:0] pt_q, pt_d;
  logic       acc;

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = state_q == ST_OUT;
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    pt_d    = pt_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    cmd_o.pt   = pt_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (req_type_i)
            tils_pkg::REQ_POS:    cmd_o.wr_pos = 1'b1;
            tils_pkg::REQ_ENERGY: cmd_o.wr_energy = 1'b1;
            tils_pkg::REQ_QUERY: begin
              cmd_o.query_ld = 1'b1;
              state_d = ST_LOAD;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin cmd_o.sort_ld = 1'b1; state_d = ST_S1; end
      ST_S1:   begin cmd_o.sort1 = 1'b1; state_d = ST_S2; end
      ST_S2:   begin cmd_o.sort2 = 1'b1; state_d = ST_S3; end
      ST_S3:   begin cmd_o.sort3 = 1'b1; state_d = ST_CLS; end
      ST_CLS: begin
        cmd_o.classify = 1'b1;
        pt_d = 2'd0;
        if (sts_i.nosurf) begin
          cmd_o.out_ns = 1'b1;
          state_d = ST_OUT;
        end else begin
          state_d = ST_DINI;
        end
      end
      ST_DINI: begin
        cmd_o.div_init = 1'b1;
        cnt_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(tils_pkg::DIV_STEPS - 1)) begin
          state_d = ST_RDB;
        end
      end
      ST_RDB: begin cmd_o.rd_base = 1'b1; state_d = ST_RDO; end
      ST_RDO: begin
        cmd_o.rd_other = 1'b1;
        axis_d = 2'd0;
        state_d = ST_MUL;
      end
      ST_MUL: begin cmd_o.mul = 1'b1; state_d = ST_ADD; end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        if (axis_q == 2'd2) begin
          cmd_o.out_pt = 1'b1;
          state_d = ST_OUT;
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end else begin
            pt_d = pt_q + 2'd1;
            state_d = ST_DINI;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      axis_q  <= '0;
      pt_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
      pt_q    <= pt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tetra_iso_level_slicer.sv */
// channel    direction  tdata                                      tuser     tlast
// s_axis     in         slot, band, x, y, z, energy, level (168b)  req_type  -
// m_axis     out        point x, y, z, corner_count (104b)         status    last_point
//
// loads are accepted back to back while no query is in flight
// a query reads the energies, sorts and classifies them, then computes each point
// with the shared divider and the shared multiplier, one axis at a time, and holds
// it until m_axis_tready; a no-surface result skips the divider and multiplier
// rst_ni clears the controller only; positions and energies are undefined until loaded
`default_nettype none

module tetra_iso_level_slicer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [167:0] s_axis_tdata_i,  // slot, band, x, y, z, energy, level
  input  logic [1:0]   s_axis_tuser_i,  // req_type
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [103:0] m_axis_tdata_o,  // point_x, point_y, point_z, corner_count
  output logic         m_axis_tuser_o,  // status
  output logic         m_axis_tlast_o
);

  tils_pkg::tils_cmd_t cmd;
  tils_pkg::tils_sts_t sts;
  logic [31:0] px, py, pz;
  logic [2:0]  cnt;

  tils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .req_type_i  (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tils_dpath u_dpath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .vertex_slot_i  (s_axis_tdata_i[1:0]),
    .band_i         (s_axis_tdata_i[5:2]),
    .coord_x_i      (s_axis_tdata_i[37:6]),
    .coord_y_i      (s_axis_tdata_i[69:38]),
    .coord_z_i      (s_axis_tdata_i[101:70]),
    .energy_i       (s_axis_tdata_i[133:102]),
    .iso_level_i    (s_axis_tdata_i[165:134]),
    .point_x_o      (px),
    .point_y_o      (py),
    .point_z_o      (pz),
    .corner_count_o (cnt),
    .status_o       (m_axis_tuser_o),
    .last_point_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'd0, cnt, pz, py, px};

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int LIMIT = 400000;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [2:0]         cnt;
    logic               st, last;
  } point_t;

  typedef struct {
    logic [1:0]         typ;
    logic [1:0]         slot;
    logic [3:0]         band;
    logic signed [31:0] x, y, z, e, lvl;
    logic               typed;
  } row_t;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [103:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  tetra_iso_level_slicer u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser), .m_axis_tlast_o(m_tlast)
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  logic signed [31:0] pos_x [tils_pkg::NUM_SLOTS];
  logic signed [31:0] pos_y [tils_pkg::NUM_SLOTS];
  logic signed [31:0] pos_z [tils_pkg::NUM_SLOTS];
  logic signed [31:0] band_energy [tils_pkg::NUM_SLOTS*tils_pkg::NUM_BANDS];
  logic [tils_pkg::NUM_SLOTS-1:0] band_loaded [tils_pkg::NUM_BANDS];
  point_t pending_points [$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  function automatic void queue_point(point_t p);
    pending_points.insert(pending_points.size(), p);
  endfunction

  function automatic logic [15:0] cut_frac(longint num, longint den);
    longint q;
    if (den <= 0 || num <= 0) return 16'd0;
    q = (num <<< 16) / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [31:0] lerp(logic signed [31:0] base, logic signed [31:0] other,
                                       logic [15:0] t);
    longint b, p, q;
    b = base;
    p = (longint'(other) - b) * longint'({1'b0, t});
    if (p >= 0) q = p >>> 16;
    else q = -((-p + 65535) >>> 16);
    return 32'(b + q);
  endfunction

  function automatic point_t edge_point(int sb, int so, logic [15:0] t, int cnt, bit last);
    point_t r;
    r.x = lerp(pos_x[sb], pos_x[so], t);
    r.y = lerp(pos_y[sb], pos_y[so], t);
    r.z = lerp(pos_z[sb], pos_z[so], t);
    r.cnt = 3'(cnt);
    r.st = 0;
    r.last = last;
    return r;
  endfunction

  function automatic point_t no_surface();
    point_t r;
    r.x = 0; r.y = 0; r.z = 0; r.cnt = 0; r.st = 1; r.last = 1;
    return r;
  endfunction

  task automatic slice_predict(row_t r);
    longint e [4];
    longint lv, te;
    int s [4];
    int ts;
    int pairs [5][2] = '{'{0, 1}, '{2, 3}, '{0, 2}, '{1, 3}, '{1, 2}};
    case (r.typ)
      tils_pkg::REQ_POS: begin
        pos_x[r.slot] = r.x; pos_y[r.slot] = r.y; pos_z[r.slot] = r.z;
      end
      tils_pkg::REQ_ENERGY: begin
        band_energy[r.slot*tils_pkg::NUM_BANDS + r.band] = r.e;
        band_loaded[r.band][r.slot] = 1'b1;
      end
      tils_pkg::REQ_QUERY: begin
        for (int i = 0; i < 4; i++) begin
          s[i] = tils_pkg::SLOT_START[i];
          e[i] = band_energy[i*tils_pkg::NUM_BANDS + r.band];
        end
        foreach (pairs[k]) begin
          if (e[pairs[k][0]] > e[pairs[k][1]]) begin
            te = e[pairs[k][0]]; e[pairs[k][0]] = e[pairs[k][1]]; e[pairs[k][1]] = te;
            ts = s[pairs[k][0]]; s[pairs[k][0]] = s[pairs[k][1]]; s[pairs[k][1]] = ts;
          end
        end
        lv = r.lvl;
        if (lv < e[0] || lv > e[3]) begin
          queue_point(no_surface());
        end else if (lv < e[1]) begin
          queue_point(edge_point(s[0], s[1], cut_frac(lv-e[0], e[1]-e[0]), 3, 0));
          queue_point(edge_point(s[0], s[2], cut_frac(lv-e[0], e[2]-e[0]), 3, 0));
          queue_point(edge_point(s[0], s[3], cut_frac(lv-e[0], e[3]-e[0]), 3, 1));
        end else if (lv < e[2]) begin
          queue_point(edge_point(s[0], s[2], cut_frac(lv-e[0], e[2]-e[0]), 4, 0));
          queue_point(edge_point(s[0], s[3], cut_frac(lv-e[0], e[3]-e[0]), 4, 0));
          queue_point(edge_point(s[2], s[1], cut_frac(e[2]-lv, e[2]-e[1]), 4, 0));
          queue_point(edge_point(s[1], s[3], cut_frac(lv-e[1], e[3]-e[1]), 4, 1));
        end else begin
          queue_point(edge_point(s[3], s[2], cut_frac(e[3]-lv, e[3]-e[2]), 3, 0));
          queue_point(edge_point(s[3], s[1], cut_frac(e[3]-lv, e[3]-e[1]), 3, 0));
          queue_point(edge_point(s[3], s[0], cut_frac(e[3]-lv, e[3]-e[0]), 3, 1));
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= r.typ;
    s_tdata <= {2'b00, r.lvl, r.e, r.z, r.y, r.x, r.band, r.slot};
    forever begin
      @(negedge clk_i);
      if (s_tready) break;
      @(posedge clk_i);
    end
    // item accepted at the coming edge
    if (r.typed) queue_point(no_surface());
    else slice_predict(r);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles % 64 < 16) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(negedge clk_i) begin
    point_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.x = m_tdata[31:0]; got.y = m_tdata[63:32]; got.z = m_tdata[95:64];
      got.cnt = m_tdata[98:96]; got.st = m_tuser; got.last = m_tlast;
      if (pending_points.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: %p", got);
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.cnt !== want.cnt || got.st !== want.st || got.last !== want.last) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic row_t mk(logic [1:0] typ, logic [1:0] slot, logic [3:0] band,
                              int x, int y, int z, int e, int lvl, bit typed);
    row_t r;
    r.typ = typ; r.slot = slot; r.band = band;
    r.x = x; r.y = y; r.z = z; r.e = e; r.lvl = lvl; r.typed = typed;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_energy(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8)) <<< 16;
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  row_t directed [$];
  row_t r;
  int full [$];
  longint lo, hi;
  int b, mode;

  initial begin
    foreach (band_loaded[i]) band_loaded[i] = '0;
    directed = '{
      mk(tils_pkg::REQ_POS, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0),
      mk(tils_pkg::REQ_POS, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0),
      mk(tils_pkg::REQ_POS, 2, 0, 0, 32'h0001_0000, 32'h8000_0000, 0, 0, 0),
      mk(tils_pkg::REQ_POS, 3, 0, 32'hFFFF_0000, 32'h0000_8000, 32'h7FFF_FFFF, 0, 0, 0),
      mk(tils_pkg::REQ_ENERGY, 0, 0, 0, 0, 0, 3 <<< 16, 0, 0),
      mk(tils_pkg::REQ_ENERGY, 1, 0, 0, 0, 0, 1 <<< 16, 0, 0),
      mk(tils_pkg::REQ_ENERGY, 2, 0, 0, 0, 0, 2 <<< 16, 0, 0),
      mk(tils_pkg::REQ_ENERGY, 3, 0, 0, 0, 0, 0, 0, 0),
      mk(tils_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 1),
      mk(tils_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1),
      mk(tils_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(tils_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 32'h0000_8000, 0),
      mk(tils_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 1 <<< 16, 0),
      mk(tils_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 2 <<< 16, 0),
      mk(tils_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 3 <<< 16, 0),
      mk(tils_pkg::REQ_ENERGY, 0, 15, 0, 0, 0, 5, 0, 0),
      mk(tils_pkg::REQ_ENERGY, 1, 15, 0, 0, 0, 5, 0, 0),
      mk(tils_pkg::REQ_ENERGY, 2, 15, 0, 0, 0, 5, 0, 0),
      mk(tils_pkg::REQ_ENERGY, 3, 15, 0, 0, 0, 5, 0, 0),
      mk(tils_pkg::REQ_QUERY, 0, 15, 0, 0, 0, 0, 5, 0),
      mk(REQ_NONE, 3, 15, -1, -1, -1, -1, -1, 0),
      mk(tils_pkg::REQ_QUERY, 3, 15, 0, 0, 0, 0, 4, 1)
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_item(directed[i]);

    for (int n = 0; n < 80; n++) begin
      if (n == 40) begin
        s_tvalid <= 1'b0;
        burst_left = 0;
        wait (pending_points.size() == 0);
        @(posedge clk_i);
      end
      full = {};
      foreach (band_loaded[i]) if (&band_loaded[i]) full.insert(full.size(), i);
      r = mk(2'($urandom_range(0, 3)), 2'($urandom), 4'($urandom), $urandom, $urandom,
             $urandom, 0, $urandom, 0);
      mode = $urandom_range(0, 9);
      if (mode < 2) r.typ = tils_pkg::REQ_POS;
      else if (mode < 5 || full.size() == 0) r.typ = tils_pkg::REQ_ENERGY;
      else if (mode < 9) r.typ = tils_pkg::REQ_QUERY;
      else r.typ = REQ_NONE;
      if (r.typ == tils_pkg::REQ_ENERGY) r.e = rand_energy($urandom_range(0, 2));
      if (r.typ == tils_pkg::REQ_QUERY) begin
        b = full[$urandom_range(0, full.size() - 1)];
        r.band = 4'(b);
        lo = band_energy[b]; hi = lo;
        for (int k = 1; k < 4; k++) begin
          if (band_energy[k*tils_pkg::NUM_BANDS + b] < lo) begin
            lo = band_energy[k*tils_pkg::NUM_BANDS + b];
          end
          if (band_energy[k*tils_pkg::NUM_BANDS + b] > hi) begin
            hi = band_energy[k*tils_pkg::NUM_BANDS + b];
          end
        end
        case ($urandom_range(0, 5))
          0: r.lvl = band_energy[$urandom_range(0, 3)*tils_pkg::NUM_BANDS + b];
          1: r.lvl = $urandom;
          2: r.lvl = ($urandom_range(0, 1)) ? 32'(lo - 1) : 32'(hi + 1);
          default: r.lvl = 32'(lo + longint'($urandom) % (hi - lo + 1));
        endcase
      end
      send_item(r);
    end
    s_tvalid <= 1'b0;

    wait (pending_points.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
